// ===== rtl/core/name_value_pair_parser_defines.svh =====
// assertion macros shared by the name-value pair parser checkers
// expects signals named clk and rst in the scope of use
`ifndef NAME_VALUE_PAIR_PARSER_DEFINES_SVH
`define NAME_VALUE_PAIR_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NVP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/nvp_pkg.sv =====
// types and constants of the name-value pair parser
// no dependencies
`default_nettype none

package nvp_pkg;

  localparam int ACCUM_BITS = 31;

  // bytes that follow the first byte of a four-byte length
  localparam logic [1:0] PREFIX_TAIL = 2'd3;

  localparam logic [7:0] LONG_MARK    = 8'h80;
  localparam logic [7:0] LEN_LOW_MASK = 8'h7F;

  typedef enum logic [2:0] {
    PH_NLEN      = 3'd0,
    PH_NLEN_MORE = 3'd1,
    PH_VLEN      = 3'd2,
    PH_VLEN_MORE = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LEN   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       field_end;
    logic       pair_end;
    logic       status;
    logic       body_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/nvp_channels.sv =====
// valid/ready channels of the name-value pair parser
// body bytes in, classified bytes out; no dependencies
`default_nettype none

interface nvp_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_end;

  modport source (output valid, output data_byte, output body_end, input ready);
  modport sink (input valid, input data_byte, input body_end, output ready);
endinterface

interface nvp_parsed_if;
  logic       valid;
  logic       ready;
  logic [1:0] byte_kind;
  logic [7:0] byte_out;
  logic       field_end;
  logic       pair_end;
  logic       status;
  logic       body_done;

  modport source (
    output valid, output byte_kind, output byte_out, output field_end,
    output pair_end, output status, output body_done, input ready
  );
  modport sink (
    input valid, input byte_kind, input byte_out, input field_end,
    input pair_end, input status, input body_done, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/nvp_decoder.sv =====
// parse state and per-byte classification of the name-value pair parser
// depends on nvp_pkg
`default_nettype none

module nvp_decoder #(
  parameter int LENGTH_BITS = 31
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            body_end,
  output nvp_pkg::result_t     result
);

  nvp_pkg::phase_t                  phase, phase_next;
  logic [nvp_pkg::ACCUM_BITS-1:0]   length_accum, length_accum_next;
  logic [1:0]                       prefix_bytes_left, prefix_bytes_left_next;
  logic [LENGTH_BITS-1:0]           name_left, name_left_next;
  logic [LENGTH_BITS-1:0]           value_left, value_left_next;

  logic [nvp_pkg::ACCUM_BITS-1:0]   accum_shift;
  logic [1:0]                       prefix_dec;
  logic [LENGTH_BITS-1:0]           name_dec, value_dec;
  logic [LENGTH_BITS-1:0]           len_word;
  logic                             is_long;
  logic                             in_more;
  logic                             is_value;
  logic                             len_complete;

  assign accum_shift = {length_accum[nvp_pkg::ACCUM_BITS-9:0], data_byte};
  assign prefix_dec  = prefix_bytes_left - 2'd1;
  assign name_dec    = name_left - LENGTH_BITS'(1);
  assign value_dec   = value_left - LENGTH_BITS'(1);
  assign is_long     = (data_byte & nvp_pkg::LONG_MARK) != 8'h00;
  assign in_more     = (phase == nvp_pkg::PH_NLEN_MORE) || (phase == nvp_pkg::PH_VLEN_MORE);
  assign is_value    = (phase == nvp_pkg::PH_VLEN) || (phase == nvp_pkg::PH_VLEN_MORE);

  // name and value phases never complete a length
  always_comb begin
    if (in_more) begin
      len_complete = (prefix_dec == 2'd0);
    end else if ((phase == nvp_pkg::PH_NAME) || (phase == nvp_pkg::PH_VALUE)) begin
      len_complete = 1'b0;
    end else begin
      len_complete = !is_long;
    end
  end

  // finished length, saturated to the counter width
  always_comb begin
    if (in_more) begin
      if ((accum_shift >> LENGTH_BITS) != '0) begin
        len_word = '1;
      end else begin
        len_word = accum_shift[LENGTH_BITS-1:0];
      end
    end else begin
      len_word = LENGTH_BITS'(data_byte);
    end
  end

  // next state
  always_comb begin
    phase_next             = phase;
    length_accum_next      = length_accum;
    prefix_bytes_left_next = prefix_bytes_left;
    name_left_next         = name_left;
    value_left_next        = value_left;
    case (phase)
      nvp_pkg::PH_NLEN_MORE, nvp_pkg::PH_VLEN_MORE: begin
        length_accum_next      = accum_shift;
        prefix_bytes_left_next = prefix_dec;
      end
      nvp_pkg::PH_NAME: begin
        name_left_next = name_dec;
        if (name_dec == '0) begin
          phase_next = (value_left != '0) ? nvp_pkg::PH_VALUE : nvp_pkg::PH_NLEN;
        end
      end
      nvp_pkg::PH_VALUE: begin
        value_left_next = value_dec;
        if (value_dec == '0) begin
          phase_next = nvp_pkg::PH_NLEN;
        end
      end
      default: begin
        // name length or value length, first byte
        if (is_long) begin
          length_accum_next      = nvp_pkg::ACCUM_BITS'(data_byte & nvp_pkg::LEN_LOW_MASK);
          prefix_bytes_left_next = nvp_pkg::PREFIX_TAIL;
          phase_next = is_value ? nvp_pkg::PH_VLEN_MORE : nvp_pkg::PH_NLEN_MORE;
        end
      end
    endcase
    if (len_complete) begin
      if (is_value) begin
        value_left_next = len_word;
        if (name_left != '0) begin
          phase_next = nvp_pkg::PH_NAME;
        end else if (len_word != '0) begin
          phase_next = nvp_pkg::PH_VALUE;
        end else begin
          phase_next = nvp_pkg::PH_NLEN;
        end
      end else begin
        name_left_next = len_word;
        phase_next     = nvp_pkg::PH_VLEN;
      end
    end
  end

  // outputs
  always_comb begin
    result.kind      = nvp_pkg::KIND_LEN;
    result.data      = data_byte;
    result.field_end = 1'b0;
    result.pair_end  = 1'b0;
    result.status    = body_end && (phase_next != nvp_pkg::PH_NLEN);
    result.body_done = body_end;
    case (phase)
      nvp_pkg::PH_NAME: begin
        result.kind      = nvp_pkg::KIND_NAME;
        result.field_end = (name_dec == '0);
        result.pair_end  = (name_dec == '0) && (value_left == '0);
      end
      nvp_pkg::PH_VALUE: begin
        result.kind      = nvp_pkg::KIND_VALUE;
        result.field_end = (value_dec == '0);
        result.pair_end  = (value_dec == '0);
      end
      default: begin
        // both fields empty: the value length closes the pair
        result.pair_end = len_complete && is_value && (name_left == '0) && (len_word == '0);
      end
    endcase
  end

  // end of body returns everything to the between-pairs state
  always_ff @(posedge clk) begin
    if (rst || (step && body_end)) begin
      phase             <= nvp_pkg::PH_NLEN;
      length_accum      <= '0;
      prefix_bytes_left <= '0;
      name_left         <= '0;
      value_left        <= '0;
    end else if (step) begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      prefix_bytes_left <= prefix_bytes_left_next;
      name_left         <= name_left_next;
      value_left        <= value_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/name_value_pair_parser.sv =====
// output: an accepted word is registered in the result register and shows on the output channel in the next cycle
// throughput: one body byte per cycle while the output side takes each result; the phase and length
// counters are updated on each accepted byte, and a new byte enters in the same cycle that the waiting result is taken
// reset: rst (synchronous) empties the output register, holds ready low and returns the parser
// to expect a name length; a byte marked body_end does the same for the parse state
`default_nettype none

module name_value_pair_parser #(
  parameter int LENGTH_BITS = 31
) (
  input wire logic     clk,
  input wire logic     rst,
  nvp_body_if.sink     body,
  nvp_parsed_if.source parsed
);

  nvp_pkg::result_t dec_result;
  nvp_pkg::result_t result;
  logic             result_valid;
  logic             accept;

  assign body.ready = !rst && (!result_valid || parsed.ready);
  assign accept     = body.valid && body.ready;

  nvp_decoder #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .data_byte (body.data_byte),
    .body_end  (body.body_end),
    .result    (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (parsed.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= dec_result;
    end
  end

  assign parsed.valid     = result_valid;
  assign parsed.byte_kind = result.kind;
  assign parsed.byte_out  = result.data;
  assign parsed.field_end = result.field_end;
  assign parsed.pair_end  = result.pair_end;
  assign parsed.status    = result.status;
  assign parsed.body_done = result.body_done;

endmodule

`default_nettype wire

// ===== rtl/core/nvp_checker.sv =====
// port-level checks of the name-value pair parser, bound to the top level
// depends on nvp_pkg and name_value_pair_parser_defines.svh
`default_nettype none
`include "name_value_pair_parser_defines.svh"

module nvp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_field_end,
  input wire logic       out_status,
  input wire logic       out_body_done
);

  `NVP_ASSERT_NEXT(a_word_out_next, in_valid && in_ready, out_valid && (out_byte == $past(in_byte)), "accepted word not shown next cycle")
  `NVP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind), "stalled word changed")
  `NVP_ASSERT_IMPLY(a_field_end_kind, out_valid && out_field_end, (out_kind == nvp_pkg::KIND_NAME) || (out_kind == nvp_pkg::KIND_VALUE), "field end on a length byte")
  `NVP_ASSERT_IMPLY(a_status_at_end, out_valid && out_status, out_body_done, "malformed flag without body end")

endmodule

bind name_value_pair_parser nvp_checker u_nvp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (body.valid),
  .in_ready      (body.ready),
  .in_byte       (body.data_byte),
  .out_valid     (parsed.valid),
  .out_ready     (parsed.ready),
  .out_kind      (parsed.byte_kind),
  .out_byte      (parsed.byte_out),
  .out_field_end (parsed.field_end),
  .out_status    (parsed.status),
  .out_body_done (parsed.body_done)
);

`default_nettype wire

// ===== tb/tb_name_value_pair_parser.sv =====
`timescale 1ns / 100ps
// testbench for name_value_pair_parser: random and directed parameter bodies, checked
// byte by byte against an in-bench parser model
// depends on nvp_pkg and the channel interfaces in nvp_channels.sv
`default_nettype none

module tb_name_value_pair_parser;

  localparam int LEN_BITS = 31;
  localparam logic [30:0] LEN_MAX = (31'd1 << LEN_BITS) - 31'd1;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_WORDS = 500;

  // {body_end, data_byte}
  localparam logic [8:0] DIRECTED_WORDS [0:26] = '{
    9'h001, 9'h001, 9'h041, 9'h142,
    9'h000, 9'h100,
    9'h000, 9'h002, 9'h0FF, 9'h100,
    9'h002, 9'h000, 9'h07F, 9'h080,
    9'h080, 9'h000, 9'h000, 9'h001, 9'h000, 9'h15A,
    9'h100,
    9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h181
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nvp_body_if   body ();
  nvp_parsed_if parsed ();

  name_value_pair_parser #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .body  (body),
    .parsed(parsed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  body_word_t       pending_words[$];
  body_word_t       body_buf[$];
  nvp_pkg::result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int err_count = 0;
  int n_bytes = 0;
  int n_bodies = 0;
  int n_pairs = 0;
  int n_bad = 0;

  // parser model state
  nvp_pkg::phase_t     ph;
  logic [30:0]         acc;
  logic [1:0]          pre_left;
  logic [LEN_BITS-1:0] nm_left;
  logic [LEN_BITS-1:0] val_left;

  function automatic void clear_parse_state();
    ph = nvp_pkg::PH_NLEN;
    acc = '0;
    pre_left = '0;
    nm_left = '0;
    val_left = '0;
  endfunction

  // a length is complete; returns 1 when it completes the pair
  function automatic logic close_length(input logic is_value, input logic [30:0] len);
    logic [LEN_BITS-1:0] sat;
    sat = (len > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : len[LEN_BITS-1:0];
    if (!is_value) begin
      nm_left = sat;
      ph = nvp_pkg::PH_VLEN;
      return 1'b0;
    end
    val_left = sat;
    if (nm_left != 0) begin
      ph = nvp_pkg::PH_NAME;
    end else if (val_left != 0) begin
      ph = nvp_pkg::PH_VALUE;
    end else begin
      ph = nvp_pkg::PH_NLEN;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic nvp_pkg::result_t classify_byte(input logic [7:0] b, input logic last);
    nvp_pkg::result_t r;
    r.kind = nvp_pkg::KIND_LEN;
    r.data = b;
    r.field_end = 1'b0;
    r.pair_end = 1'b0;
    r.status = 1'b0;
    r.body_done = last;
    case (ph)
      nvp_pkg::PH_NLEN_MORE, nvp_pkg::PH_VLEN_MORE: begin
        acc = {acc[22:0], b};
        pre_left = pre_left - 2'd1;
        if (pre_left == 0) r.pair_end = close_length(ph == nvp_pkg::PH_VLEN_MORE, acc);
      end
      nvp_pkg::PH_VLEN: begin
        if (b < nvp_pkg::LONG_MARK) begin
          r.pair_end = close_length(1'b1, {23'd0, b});
        end else begin
          acc = {23'd0, b & nvp_pkg::LEN_LOW_MASK};
          pre_left = nvp_pkg::PREFIX_TAIL;
          ph = nvp_pkg::PH_VLEN_MORE;
        end
      end
      nvp_pkg::PH_NAME: begin
        r.kind = nvp_pkg::KIND_NAME;
        nm_left = nm_left - 1'b1;
        if (nm_left == 0) begin
          r.field_end = 1'b1;
          if (val_left != 0) begin
            ph = nvp_pkg::PH_VALUE;
          end else begin
            r.pair_end = 1'b1;
            ph = nvp_pkg::PH_NLEN;
          end
        end
      end
      nvp_pkg::PH_VALUE: begin
        r.kind = nvp_pkg::KIND_VALUE;
        val_left = val_left - 1'b1;
        if (val_left == 0) begin
          r.field_end = 1'b1;
          r.pair_end = 1'b1;
          ph = nvp_pkg::PH_NLEN;
        end
      end
      default: begin
        if (b < nvp_pkg::LONG_MARK) begin
          r.pair_end = close_length(1'b0, {23'd0, b});
        end else begin
          acc = {23'd0, b & nvp_pkg::LEN_LOW_MASK};
          pre_left = nvp_pkg::PREFIX_TAIL;
          ph = nvp_pkg::PH_NLEN_MORE;
        end
      end
    endcase
    if (last) begin
      r.status = (ph != nvp_pkg::PH_NLEN);
      clear_parse_state();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus building

  function automatic void add_byte(input logic [7:0] b, input logic last);
    body_word_t w;
    w.data = b;
    w.last = last;
    body_buf = {body_buf, w};
  endfunction

  function automatic void add_length(input int unsigned len);
    logic [31:0] v;
    v = len;
    if (v < 128 && $urandom_range(3) != 0) begin
      add_byte(v[7:0], 1'b0);
    end else begin
      add_byte({1'b1, v[30:24]}, 1'b0);
      add_byte(v[23:16], 1'b0);
      add_byte(v[15:8], 1'b0);
      add_byte(v[7:0], 1'b0);
    end
  endfunction

  function automatic int unsigned pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 15) return 0;
    if (p < 85) return $urandom_range(6, 1);
    return $urandom_range(40, 7);
  endfunction

  function automatic void flush_body();
    foreach (body_buf[i]) pending_words = {pending_words, body_buf[i]};
    body_buf.delete();
  endfunction

  // mostly well-formed bodies, some cut short, some pure noise
  function automatic void queue_random_body();
    int unsigned pick, nl, vl, cut;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat ($urandom_range(4, 1)) begin
        nl = pick_length();
        vl = pick_length();
        add_length(nl);
        add_length(vl);
        repeat (nl) add_byte(8'($urandom_range(255)), 1'b0);
        repeat (vl) add_byte(8'($urandom_range(255)), 1'b0);
      end
      if (pick < 30) begin
        cut = $urandom_range(body_buf.size() - 1, 1);
        body_buf = body_buf[0:cut-1];
      end
    end
    body_buf[body_buf.size()-1].last = 1'b1;
    flush_body();
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || body.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (pending_words.size() < PHASE_WORDS) queue_random_body();
    // long receiver hold while the sender keeps offering
    if (with_hold) hold_go = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------- driver

  body_word_t       next_word;
  nvp_pkg::result_t next_result;

  always @(posedge clk) begin
    if (rst) begin
      body.valid <= 1'b0;
    end else begin
      if (body.valid && body.ready) begin
        next_result = classify_byte(body.data_byte, body.body_end);
        expected_results = {expected_results, next_result};
        n_bytes++;
        n_pairs += next_result.pair_end;
        n_bodies += next_result.body_done;
        n_bad += next_result.status;
      end
      if (!body.valid || body.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          body.valid <= 1'b1;
          body.data_byte <= next_word.data;
          body.body_end <= next_word.last;
        end else begin
          body.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  nvp_pkg::result_t want;

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      parsed.ready <= 1'b0;
    end else begin
      if (parsed.valid && parsed.ready) begin
        if (expected_results.size() == 0) begin
          $error("output word with nothing expected: byte %0h", parsed.byte_out);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("byte_kind", 8'(want.kind), 8'(parsed.byte_kind));
          check_field("byte_out", want.data, parsed.byte_out);
          check_field("field_end", 8'(want.field_end), 8'(parsed.field_end));
          check_field("pair_end", 8'(want.pair_end), 8'(parsed.pair_end));
          check_field("status", 8'(want.status), 8'(parsed.status));
          check_field("body_done", 8'(want.body_done), 8'(parsed.body_done));
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        parsed.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        parsed.ready <= 1'b0;
      end else begin
        parsed.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (body.valid && body.ready) || (parsed.valid && parsed.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    body.valid = 1'b0;
    body.data_byte = 8'h00;
    body.body_end = 1'b0;
    parsed.ready = 1'b0;
    clear_parse_state();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_WORDS[i]) add_byte(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][8]);
    flush_body();
    wait_drained();

    run_phase(12, 75, 1'b0);
    run_phase(75, 12, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (4) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected words never came out", expected_results.size());
      err_count++;
    end
    $display("parsed %0d bytes in %0d bodies: %0d pairs completed, %0d bodies malformed",
             n_bytes, n_bodies, n_pairs, n_bad);
    $display("idle mixes: sender-light, receiver-light, none; one %0d-cycle output hold",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
